>>> hw/rtl/thread_region_slot_table_top_macros.svh
// Assertion macros shared by the checker of the slot table.
`ifndef THREAD_REGION_SLOT_TABLE_TOP_MACROS_SVH
`define THREAD_REGION_SLOT_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRST_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TRST_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> hw/rtl/trst_pkg.sv
`default_nettype none

package trst_pkg;

	localparam int SLOTS        = 16;
	localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RESULT_LIMIT = 32;
	localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

	localparam logic [15:0] CBS_RESET = 16'd256;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_DELETE = 2'd1,
		OP_ENUM   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CREATE,
		S_DEL_SEEK,
		S_DEL_CMP,
		S_ENUM_SEEK,
		S_ENUM_CTRL,
		S_ENUM_STACK,
		S_ACK
	} state_t;

	typedef struct packed {
		logic    load;
		logic    seek;
		logic    advance;
		logic    create_wr;
		logic    del_clr;
		logic    emit_ack;
		status_t ack_status;
		logic    emit_ctrl;
		logic    emit_stack;
		logic    stack_last;
	} cmd_t;

	typedef struct packed {
		logic key_zero;
		logic full;
		logic found;
		logic budget_ok;
		logic key_match;
		logic scan_top;
		logic more;
	} sts_t;

	// Lowest set bit of v, as {found, index}.
	function automatic logic [SLOT_W:0] first_set(input logic [SLOTS-1:0] v);
		logic [SLOT_W:0] r;
		r = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, SLOT_W'(i)};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/thread_region_slot_table_top.sv
// Sequence: create and the unused opcode pass through S_CREATE or S_ACK; a delete
// alternates S_DEL_SEEK and S_DEL_CMP per occupied slot compared, ending on a hit, on the
// top slot or with no occupied slot left; a key of zero ends in S_DEL_SEEK. Enumerate runs
// S_ENUM_SEEK, S_ENUM_CTRL and S_ENUM_STACK per pair; an empty one ends in S_ENUM_SEEK.
// One item at a time: busy drops when the final beat is shown; the receiver cannot stall.
// Reset: all slots empty, control block size 256, no beat pending.
`default_nettype none

module thread_region_slot_table_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] thread_addr,
	input  wire logic [31:0] stack_addr,
	input  wire logic [31:0] stack_bytes,
	input  wire logic [7:0]  region_capacity,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output logic             busy,
	output logic             strobe,
	output logic [31:0]      region_addr,
	output logic [31:0]      region_size,
	output logic             region_valid,
	output logic [7:0]       region_count,
	output logic [1:0]       status,
	output logic             last
);

	trst_pkg::cmd_t cmd;
	trst_pkg::sts_t sts;

	trst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	trst_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.thread_addr     (thread_addr),
		.stack_addr      (stack_addr),
		.stack_bytes     (stack_bytes),
		.region_capacity (region_capacity),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.strobe          (strobe),
		.region_addr     (region_addr),
		.region_size     (region_size),
		.region_valid    (region_valid),
		.region_count    (region_count),
		.status          (status),
		.last            (last)
	);

endmodule

`default_nettype wire

>>> hw/rtl/trst_ctrl.sv
`default_nettype none

module trst_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    opcode,
	input  wire trst_pkg::sts_t sts,
	output trst_pkg::cmd_t     cmd,
	output logic               busy
);

	trst_pkg::state_t state_q;
	trst_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != trst_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			trst_pkg::S_IDLE: begin
				if (start) begin
					unique case (trst_pkg::opcode_t'(opcode))
						trst_pkg::OP_CREATE: state_d = trst_pkg::S_CREATE;
						trst_pkg::OP_DELETE: state_d = trst_pkg::S_DEL_SEEK;
						trst_pkg::OP_ENUM:   state_d = trst_pkg::S_ENUM_SEEK;
						trst_pkg::OP_NONE:   state_d = trst_pkg::S_ACK;
					endcase
				end
			end
			trst_pkg::S_CREATE: state_d = trst_pkg::S_IDLE;
			trst_pkg::S_DEL_SEEK: begin
				if (!sts.key_zero && sts.found) begin
					state_d = trst_pkg::S_DEL_CMP;
				end else begin
					state_d = trst_pkg::S_IDLE;
				end
			end
			trst_pkg::S_DEL_CMP: begin
				if (sts.key_match || sts.scan_top) begin
					state_d = trst_pkg::S_IDLE;
				end else begin
					state_d = trst_pkg::S_DEL_SEEK;
				end
			end
			trst_pkg::S_ENUM_SEEK: begin
				if (sts.found && sts.budget_ok) begin
					state_d = trst_pkg::S_ENUM_CTRL;
				end else begin
					state_d = trst_pkg::S_IDLE;
				end
			end
			trst_pkg::S_ENUM_CTRL: state_d = trst_pkg::S_ENUM_STACK;
			trst_pkg::S_ENUM_STACK: begin
				if (sts.more) begin
					state_d = trst_pkg::S_ENUM_SEEK;
				end else begin
					state_d = trst_pkg::S_IDLE;
				end
			end
			trst_pkg::S_ACK: state_d = trst_pkg::S_IDLE;
			default: state_d = trst_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.ack_status = trst_pkg::STAT_DONE;
		unique case (state_q)
			trst_pkg::S_IDLE: begin
				cmd.load = start;
			end
			trst_pkg::S_CREATE: begin
				// A zero key finds a free slot but leaves it empty.
				cmd.create_wr  = !sts.full && !sts.key_zero;
				cmd.emit_ack   = 1'b1;
				cmd.ack_status = sts.full ? trst_pkg::STAT_FULL : trst_pkg::STAT_DONE;
			end
			trst_pkg::S_DEL_SEEK: begin
				if (sts.key_zero) begin
					// A zero key matches the lowest empty slot, which stays empty.
					cmd.emit_ack   = 1'b1;
					cmd.ack_status = sts.full ? trst_pkg::STAT_NOT_FOUND
					                          : trst_pkg::STAT_DONE;
				end else if (sts.found) begin
					cmd.seek = 1'b1;
				end else begin
					cmd.emit_ack   = 1'b1;
					cmd.ack_status = trst_pkg::STAT_NOT_FOUND;
				end
			end
			trst_pkg::S_DEL_CMP: begin
				if (sts.key_match) begin
					cmd.del_clr  = 1'b1;
					cmd.emit_ack = 1'b1;
				end else if (sts.scan_top) begin
					cmd.emit_ack   = 1'b1;
					cmd.ack_status = trst_pkg::STAT_NOT_FOUND;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			trst_pkg::S_ENUM_SEEK: begin
				if (sts.found && sts.budget_ok) begin
					cmd.seek = 1'b1;
				end else begin
					// Nothing fits: the empty marker beat.
					cmd.emit_ack = 1'b1;
				end
			end
			trst_pkg::S_ENUM_CTRL: begin
				cmd.emit_ctrl = 1'b1;
			end
			trst_pkg::S_ENUM_STACK: begin
				cmd.emit_stack = 1'b1;
				cmd.stack_last = !sts.more;
				cmd.advance    = sts.more;
			end
			trst_pkg::S_ACK: begin
				cmd.emit_ack = 1'b1;
			end
			default: begin
				cmd.ack_status = trst_pkg::STAT_DONE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/trst_dp.sv
`default_nettype none

module trst_dp (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire trst_pkg::cmd_t cmd,
	output trst_pkg::sts_t   sts,
	input  wire logic [31:0] thread_addr,
	input  wire logic [31:0] stack_addr,
	input  wire logic [31:0] stack_bytes,
	input  wire logic [7:0]  region_capacity,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output logic             strobe,
	output logic [31:0]      region_addr,
	output logic [31:0]      region_size,
	output logic             region_valid,
	output logic [7:0]       region_count,
	output logic [1:0]       status,
	output logic             last
);

	logic [31:0] key_q;
	logic [31:0] saddr_q;
	logic [31:0] sbytes_q;
	logic [7:0]  cap_q;
	logic [15:0] cbs_q;

	logic [trst_pkg::SLOTS-1:0]  occ_q;
	logic [trst_pkg::SLOT_W-1:0] scan_q;
	logic [trst_pkg::CNT_W-1:0]  n_q;

	logic [31:0] thread_mem [trst_pkg::SLOTS];
	logic [31:0] saddr_mem  [trst_pkg::SLOTS];
	logic [31:0] sbytes_mem [trst_pkg::SLOTS];
	logic [31:0] rd_thread_q;
	logic [31:0] rd_saddr_q;
	logic [31:0] rd_sbytes_q;

	logic [trst_pkg::SLOTS-1:0]  ge_mask;
	logic [trst_pkg::SLOTS-1:0]  gt_mask;
	logic [trst_pkg::SLOT_W:0]   seek_res;
	logic [trst_pkg::SLOT_W:0]   free_res;
	logic [trst_pkg::SLOT_W-1:0] seek_idx;
	logic [trst_pkg::SLOT_W-1:0] free_idx;
	logic [8:0]                  n9;
	logic [8:0]                  cap9;
	logic [8:0]                  limit9;

	always_comb begin
		for (int i = 0; i < trst_pkg::SLOTS; i++) begin
			ge_mask[i] = (trst_pkg::SLOT_W'(i) >= scan_q);
			gt_mask[i] = (trst_pkg::SLOT_W'(i) > scan_q);
		end
	end

	assign seek_res = trst_pkg::first_set(occ_q & ge_mask);
	assign free_res = trst_pkg::first_set(~occ_q);
	assign seek_idx = seek_res[trst_pkg::SLOT_W-1:0];
	assign free_idx = free_res[trst_pkg::SLOT_W-1:0];

	assign n9     = 9'(n_q);
	assign cap9   = {1'b0, cap_q};
	assign limit9 = 9'(trst_pkg::RESULT_LIMIT);

	assign sts.key_zero  = (key_q == 32'd0);
	assign sts.full      = &occ_q;
	assign sts.found     = seek_res[trst_pkg::SLOT_W];
	assign sts.budget_ok = ((n9 + 9'd1) < cap9) && ((n9 + 9'd2) <= limit9);
	assign sts.key_match = (rd_thread_q == key_q);
	assign sts.scan_top  = (scan_q == trst_pkg::SLOT_W'(trst_pkg::SLOTS - 1));
	// Checked while the stack beat goes out; the count does not yet include it, so the bounds add it.
	assign sts.more      = (|(occ_q & gt_mask)) && ((n9 + 9'd2) < cap9)
	                       && ((n9 + 9'd3) <= limit9);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= thread_addr;
			saddr_q  <= stack_addr;
			sbytes_q <= stack_bytes;
			cap_q    <= region_capacity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cbs_q <= trst_pkg::CBS_RESET;
		end else if (cfg_we) begin
			cbs_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.create_wr) begin
			thread_mem[free_idx] <= key_q;
			saddr_mem[free_idx]  <= saddr_q;
			sbytes_mem[free_idx] <= sbytes_q;
		end
		if (cmd.seek) begin
			rd_thread_q <= thread_mem[seek_idx];
			rd_saddr_q  <= saddr_mem[seek_idx];
			rd_sbytes_q <= sbytes_mem[seek_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			scan_q <= '0;
			n_q    <= '0;
		end else begin
			if (cmd.create_wr) begin
				occ_q[free_idx] <= 1'b1;
			end else if (cmd.del_clr) begin
				occ_q[scan_q] <= 1'b0;
			end

			if (cmd.load) begin
				scan_q <= '0;
			end else if (cmd.seek) begin
				scan_q <= seek_idx;
			end else if (cmd.advance) begin
				scan_q <= scan_q + 1'b1;
			end

			if (cmd.load) begin
				n_q <= '0;
			end else if (cmd.emit_ctrl || cmd.emit_stack) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit_ack || cmd.emit_ctrl || cmd.emit_stack;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.emit_ctrl) begin
			region_addr  <= rd_thread_q;
			region_size  <= {16'd0, cbs_q};
			region_valid <= 1'b1;
			region_count <= 8'(n_q) + 8'd1;
			status       <= trst_pkg::STAT_DONE;
			last         <= 1'b0;
		end else if (cmd.emit_stack) begin
			region_addr  <= rd_saddr_q;
			region_size  <= rd_sbytes_q;
			region_valid <= 1'b1;
			region_count <= 8'(n_q) + 8'd1;
			status       <= trst_pkg::STAT_DONE;
			last         <= cmd.stack_last;
		end else begin
			region_addr  <= 32'd0;
			region_size  <= 32'd0;
			region_valid <= 1'b0;
			region_count <= 8'd0;
			status       <= cmd.ack_status;
			last         <= 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/trst_chk.sv
`default_nettype none

`include "thread_region_slot_table_top_macros.svh"

module trst_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        strobe,
	input wire logic        region_valid,
	input wire logic [7:0]  region_count,
	input wire logic [1:0]  status,
	input wire logic        last
);

	// Acknowledge and marker beats always close their item.
	`TRST_ASSERT_NOW(a_ack_is_last, clk, arst_n, strobe && !region_valid, last, "ack beat without last")

	// Region beats carry a nonzero count and a done status.
	`TRST_ASSERT_NOW(a_region_ok, clk, arst_n, strobe && region_valid, region_count != 8'd0 && status == trst_pkg::STAT_DONE, "bad region beat")

	// Acknowledge and marker beats carry no count.
	`TRST_ASSERT_NOW(a_ack_count, clk, arst_n, strobe && !region_valid, region_count == 8'd0, "ack beat with count")

	// An accepted item keeps the block busy in the following cycle.
	`TRST_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "accepted item did not raise busy")

endmodule

bind thread_region_slot_table_top trst_chk u_trst_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.strobe       (strobe),
	.region_valid (region_valid),
	.region_count (region_count),
	.status       (status),
	.last         (last)
);

`default_nettype wire

>>> sim/thread_region_slot_table_top_tb.sv
`timescale 1ns / 100ps

module thread_region_slot_table_top_tb;

	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_TAIL  = 3 * trst_pkg::SLOTS + 10;

	typedef struct {
		logic [31:0]       addr;
		logic [31:0]       size;
		logic              valid;
		logic [7:0]        count;
		trst_pkg::status_t stat;
		logic              last;
	} region_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  opcode = 2'd0;
	logic [31:0] thread_addr = 32'd0;
	logic [31:0] stack_addr = 32'd0;
	logic [31:0] stack_bytes = 32'd0;
	logic [7:0]  region_capacity = 8'd0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        busy;
	logic        strobe;
	logic [31:0] region_addr;
	logic [31:0] region_size;
	logic        region_valid;
	logic [7:0]  region_count;
	logic [1:0]  status;
	logic        last;

	// Shadow copy of the slot table and the control block size register.
	logic [31:0]  shadow_key [trst_pkg::SLOTS];
	logic [31:0]  shadow_stack_addr [trst_pkg::SLOTS];
	logic [31:0]  shadow_stack_bytes [trst_pkg::SLOTS];
	logic [15:0]  shadow_cbs;
	region_beat_t beats_due [$];

	int errors = 0;
	int items_sent = 0;
	int beats_seen = 0;
	int full_acks = 0;
	int not_found_acks = 0;
	int empty_scans = 0;
	int deepest_scan = 0;
	int sizes_written = 0;
	int burst_left = 0;
	int stall_cycles = 0;
	bit pacing_on = 1'b1;

	thread_region_slot_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.opcode(opcode),
		.thread_addr(thread_addr),
		.stack_addr(stack_addr),
		.stack_bytes(stack_bytes),
		.region_capacity(region_capacity),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.busy(busy),
		.strobe(strobe),
		.region_addr(region_addr),
		.region_size(region_size),
		.region_valid(region_valid),
		.region_count(region_count),
		.status(status),
		.last(last)
	);

	always #5 clk = ~clk;

	function automatic int occupied_slots();
		int n;
		n = 0;
		for (int i = 0; i < trst_pkg::SLOTS; i++) begin
			if (shadow_key[i] != 32'd0) n++;
		end
		return n;
	endfunction

	// Works out the beats one accepted command causes and updates the shadow table.
	function automatic void predict_beats(input trst_pkg::opcode_t op, input logic [31:0] key,
			input logic [31:0] saddr, input logic [31:0] sbytes, input logic [7:0] cap);
		region_beat_t ack;
		region_beat_t scan [$];
		int n;
		ack = '{32'd0, 32'd0, 1'b0, 8'd0, trst_pkg::STAT_DONE, 1'b1};
		if (op == trst_pkg::OP_ENUM) begin
			n = 0;
			for (int i = 0; i < trst_pkg::SLOTS; i++) begin
				if (n + 1 >= int'(cap) || n + 2 > trst_pkg::RESULT_LIMIT) break;
				if (shadow_key[i] != 32'd0) begin
					scan.push_back('{shadow_key[i], {16'd0, shadow_cbs}, 1'b1, 8'(n + 1),
						trst_pkg::STAT_DONE, 1'b0});
					scan.push_back('{shadow_stack_addr[i], shadow_stack_bytes[i], 1'b1,
						8'(n + 2), trst_pkg::STAT_DONE, 1'b0});
					n += 2;
				end
			end
			if (scan.size() == 0) begin
				empty_scans++;
				beats_due.push_back(ack);
			end else begin
				scan[scan.size() - 1].last = 1'b1;
				if (n > deepest_scan) deepest_scan = n;
				foreach (scan[i]) beats_due.push_back(scan[i]);
			end
		end else begin
			case (op)
			trst_pkg::OP_CREATE: begin
				ack.stat = trst_pkg::STAT_FULL;
				for (int i = 0; i < trst_pkg::SLOTS; i++) begin
					if (shadow_key[i] == 32'd0) begin
						// A zero key finds a slot but leaves it empty.
						if (key != 32'd0) begin
							shadow_key[i] = key;
							shadow_stack_addr[i] = saddr;
							shadow_stack_bytes[i] = sbytes;
						end
						ack.stat = trst_pkg::STAT_DONE;
						break;
					end
				end
			end
			trst_pkg::OP_DELETE: begin
				ack.stat = trst_pkg::STAT_NOT_FOUND;
				for (int i = 0; i < trst_pkg::SLOTS; i++) begin
					if (shadow_key[i] == key) begin
						shadow_key[i] = 32'd0;
						ack.stat = trst_pkg::STAT_DONE;
						break;
					end
				end
			end
			default: begin
				ack.stat = trst_pkg::STAT_DONE;
			end
			endcase
			if (ack.stat == trst_pkg::STAT_FULL) full_acks++;
			if (ack.stat == trst_pkg::STAT_NOT_FOUND) not_found_acks++;
			beats_due.push_back(ack);
		end
	endfunction

	// Sends one command beat, keeping start high across back-to-back commands of a burst.
	task automatic send_cmd(input trst_pkg::opcode_t op, input logic [31:0] key,
			input logic [31:0] saddr, input logic [31:0] sbytes, input logic [7:0] cap);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 6);
			if (pacing_on) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		opcode <= op;
		thread_addr <= key;
		stack_addr <= saddr;
		stack_bytes <= sbytes;
		region_capacity <= cap;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_beats(op, key, saddr, sbytes, cap);
		items_sent++;
	endtask

	task automatic settle_idle();
		start <= 1'b0;
		burst_left = 0;
		while (beats_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_cbs(input logic [15:0] value);
		settle_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_cbs = value;
		sizes_written++;
	endtask

	// Mostly fresh random keys, with stored keys, small repeated keys and zero mixed in.
	function automatic logic [31:0] pick_key(input int stored_pct);
		int roll;
		int idx;
		roll = $urandom_range(0, 99);
		if (roll < stored_pct && occupied_slots() > 0) begin
			do idx = $urandom_range(0, trst_pkg::SLOTS - 1); while (shadow_key[idx] == 32'd0);
			return shadow_key[idx];
		end
		if (roll >= 92) return 32'd0;
		if (roll >= 82) return 32'($urandom_range(1, 4));
		return $urandom;
	endfunction

	function automatic logic [7:0] pick_capacity();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) return 8'($urandom_range(0, 12));
		if (roll < 60) return 8'($urandom_range(28, 36));
		if (roll < 70) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_random_item(input int create_pct, input int delete_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < create_pct)
			send_cmd(trst_pkg::OP_CREATE, pick_key(10), $urandom, $urandom, 8'($urandom));
		else if (roll < create_pct + delete_pct)
			send_cmd(trst_pkg::OP_DELETE, pick_key(70), $urandom, $urandom, 8'($urandom));
		else if (roll < 97)
			send_cmd(trst_pkg::OP_ENUM, $urandom, $urandom, $urandom, pick_capacity());
		else
			send_cmd(trst_pkg::OP_NONE, $urandom, $urandom, $urandom, 8'($urandom));
	endtask

	task automatic test_directed_edges();
		send_cmd(trst_pkg::OP_ENUM, 32'd0, 32'd0, 32'd0, 8'hFF);
		send_cmd(trst_pkg::OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_cmd(trst_pkg::OP_CREATE, 32'd0, 32'h1234_5678, 32'h0000_1000, 8'd0);
		send_cmd(trst_pkg::OP_CREATE, 32'd1, 32'd0, 32'd0, 8'd0);
		send_cmd(trst_pkg::OP_CREATE, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 8'd0);
		send_cmd(trst_pkg::OP_ENUM, 32'd0, 32'd0, 32'd0, 8'd0);
		send_cmd(trst_pkg::OP_ENUM, 32'd0, 32'd0, 32'd0, 8'd1);
		send_cmd(trst_pkg::OP_ENUM, 32'd0, 32'd0, 32'd0, 8'd2);
		send_cmd(trst_pkg::OP_ENUM, 32'd0, 32'd0, 32'd0, 8'd3);
		send_cmd(trst_pkg::OP_ENUM, 32'd0, 32'd0, 32'd0, 8'd5);
		send_cmd(trst_pkg::OP_ENUM, 32'd0, 32'd0, 32'd0, 8'hFF);
		send_cmd(trst_pkg::OP_DELETE, 32'd1, 32'd0, 32'd0, 8'd0);
		send_cmd(trst_pkg::OP_DELETE, 32'd1, 32'd0, 32'd0, 8'd0);
		// A zero key matches the lowest empty slot.
		send_cmd(trst_pkg::OP_DELETE, 32'd0, 32'd0, 32'd0, 8'd0);
		send_cmd(trst_pkg::OP_CREATE, 32'hFFFF_FFFF, 32'h0000_0004, 32'h0000_0040, 8'd0);
		send_cmd(trst_pkg::OP_DELETE, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd0);
		send_cmd(trst_pkg::OP_ENUM, 32'd0, 32'd0, 32'd0, 8'hFF);
		send_cmd(trst_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_cmd(trst_pkg::OP_NONE, 32'd0, 32'd0, 32'd0, 8'd0);
		send_cmd(trst_pkg::OP_CREATE, 32'h0000_1234, 32'hDEAD_0000, 32'h0000_0800, 8'd0);
		send_cmd(trst_pkg::OP_ENUM, 32'd0, 32'd0, 32'd0, 8'hFF);
	endtask

	task automatic test_fill_to_full();
		write_cbs(16'h0000);
		pacing_on = 1'b1;
		while (occupied_slots() < trst_pkg::SLOTS)
			send_cmd(trst_pkg::OP_CREATE, pick_key(10), $urandom, $urandom, 8'($urandom));
		repeat (3)
			send_cmd(trst_pkg::OP_CREATE, $urandom | 32'd1, $urandom, $urandom, 8'($urandom));
		send_cmd(trst_pkg::OP_CREATE, 32'd0, $urandom, $urandom, 8'($urandom));
		send_cmd(trst_pkg::OP_DELETE, 32'd0, $urandom, $urandom, 8'($urandom));
		// A full table fills the result bound exactly; capacities 33 and 32 still fit it, 31 and 30 cut the scan.
		send_cmd(trst_pkg::OP_ENUM, $urandom, $urandom, $urandom, 8'hFF);
		send_cmd(trst_pkg::OP_ENUM, $urandom, $urandom, $urandom, 8'd33);
		send_cmd(trst_pkg::OP_ENUM, $urandom, $urandom, $urandom, 8'd32);
		send_cmd(trst_pkg::OP_ENUM, $urandom, $urandom, $urandom, 8'd31);
		send_cmd(trst_pkg::OP_ENUM, $urandom, $urandom, $urandom, 8'd30);
		repeat (40) send_random_item(60, 20);
	endtask

	task automatic test_drain_to_empty();
		int k;
		write_cbs(16'hFFFF);
		pacing_on = 1'b0;
		k = 0;
		while (occupied_slots() > 0) begin
			send_cmd(trst_pkg::OP_DELETE, pick_key(100), $urandom, $urandom, 8'($urandom));
			if (++k % 4 == 0)
				send_cmd(trst_pkg::OP_ENUM, $urandom, $urandom, $urandom, pick_capacity());
		end
		send_cmd(trst_pkg::OP_DELETE, 32'd0, $urandom, $urandom, 8'($urandom));
		send_cmd(trst_pkg::OP_DELETE, $urandom | 32'd1, $urandom, $urandom, 8'($urandom));
		send_cmd(trst_pkg::OP_ENUM, $urandom, $urandom, $urandom, 8'hFF);
		pacing_on = 1'b1;
		repeat (40) send_random_item(25, 50);
	endtask

	task automatic test_random_mix();
		for (int r = 0; r < 5; r++) begin
			write_cbs(16'($urandom_range(0, 65535)));
			pacing_on = (r % 2 == 0);
			repeat (45) send_random_item(40, 30);
		end
		write_cbs(trst_pkg::CBS_RESET);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// Every strobed beat is matched against the oldest expectation.
	always @(posedge clk) begin : beat_check
		region_beat_t want;
		if (arst_n && strobe) begin
			beats_seen++;
			if (beats_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat: expected none, actual addr %h size %h last %b",
					$time, region_addr, region_size, last);
			end else begin
				want = beats_due.pop_front();
				check_field("region_addr", want.addr, region_addr);
				check_field("region_size", want.size, region_size);
				check_field("region_valid", 32'(want.valid), 32'(region_valid));
				check_field("region_count", 32'(want.count), 32'(region_count));
				check_field("status", 32'(want.stat), 32'(status));
				check_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_cycles <= 0;
		else if ((start && !busy) || strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("%0t: nothing moved for %0d cycles", $time, STALL_LIMIT);
		$display("thread_region_slot_table_top_tb: FAIL");
		$finish;
	end

	initial begin
		shadow_cbs = trst_pkg::CBS_RESET;
		for (int i = 0; i < trst_pkg::SLOTS; i++) begin
			shadow_key[i] = 32'd0;
			shadow_stack_addr[i] = 32'd0;
			shadow_stack_bytes[i] = 32'd0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_fill_to_full();
		test_drain_to_empty();
		test_random_mix();
		settle_idle();
		repeat (DRAIN_TAIL) @(posedge clk);
		$display("Sent %0d commands and checked %0d beats under %0d block size settings.",
			items_sent, beats_seen, sizes_written);
		$display("Saw %0d full creates, %0d missed deletes, %0d empty scans, longest scan %0d.",
			full_acks, not_found_acks, empty_scans, deepest_scan);
		if (errors == 0)
			$display("thread_region_slot_table_top_tb: PASS");
		else
			$display("thread_region_slot_table_top_tb: FAIL");
		$finish;
	end

endmodule
